FILE: hw/rtl/lps_pkg.sv
package lps_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int NUM_LIGHTS     = 6;
  localparam int LEVEL_W        = 7;
  localparam int DELTA_W        = 16;
  localparam int RND_W          = 15;
  localparam int MODE_W         = 3;
  localparam int DIVISOR_W      = 20;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 20;

  localparam logic [MODE_W-1:0] MODE_CHASE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PULSE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_EVENODD = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHASE2  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FADE    = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RESET   = 3'd7;

  localparam logic [2:0] NO_LIGHT = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_FADE_TIME    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHASE_CYCLE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_CYCLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EVENODD      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHASE2_CYCLE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POP_PULSE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TIMEOUT = 3'd7;

  typedef struct packed {
    logic [15:0] fade_time_ms;
    logic [7:0]  idle_max_seconds;
    logic [15:0] chase_cycle_ms;
    logic [15:0] pulse_cycle_ms;
    logic [15:0] even_odd_cycle_ms;
    logic [15:0] chase2_cycle_ms;
    logic [15:0] pop_pulse_ms;
    logic [19:0] long_timeout_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fade_time_ms:      16'd3000,
    idle_max_seconds:  8'd30,
    chase_cycle_ms:    16'd1000,
    pulse_cycle_ms:    16'd1000,
    even_odd_cycle_ms: 16'd2000,
    chase2_cycle_ms:   16'd5000,
    pop_pulse_ms:      16'd500,
    long_timeout_ms:   20'd20000
  };

  // 100 - |100 - x|, x in 0..200
  function automatic logic [LEVEL_W-1:0] tri_level(input logic [8:0] x);
    logic [8:0] d;
    d = 9'd200 - x;
    return (x > 9'd100) ? d[LEVEL_W-1:0] : x[LEVEL_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/lps_in_if.sv
interface lps_in_if;
  logic                      valid;
  logic                      ready;
  logic [lps_pkg::DELTA_W-1:0] step_ms;
  logic [lps_pkg::RND_W-1:0]   random_word;

  modport source (output valid, output step_ms, output random_word, input ready);
  modport sink   (input valid, input step_ms, input random_word, output ready);
endinterface

FILE: hw/rtl/lps_out_if.sv
interface lps_out_if;
  logic                        valid;
  logic                        ready;
  logic [lps_pkg::LEVEL_W-1:0] level_0;
  logic [lps_pkg::LEVEL_W-1:0] level_1;
  logic [lps_pkg::LEVEL_W-1:0] level_2;
  logic [lps_pkg::LEVEL_W-1:0] level_3;
  logic [lps_pkg::LEVEL_W-1:0] level_4;
  logic [lps_pkg::LEVEL_W-1:0] level_5;
  logic [lps_pkg::MODE_W-1:0]  pattern_mode;

  modport source (output valid, output level_0, output level_1, output level_2,
                  output level_3, output level_4, output level_5,
                  output pattern_mode, input ready);
  modport sink   (input valid, input level_0, input level_1, input level_2,
                  input level_3, input level_4, input level_5,
                  input pattern_mode, output ready);
endinterface

FILE: hw/rtl/lps_cfg_if.sv
interface lps_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [lps_pkg::CFG_IDX_W-1:0]  index;
  logic [lps_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/lps_div.sv
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
module lps_div #(
  parameter int DW = lps_pkg::COUNT_BITS_DEF + 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            go,
  input  logic [DW-1:0]                   dividend,
  input  logic [lps_pkg::DIVISOR_W-1:0]   divisor,
  output logic                            done,
  output logic [DW-1:0]                   quotient,
  output logic [lps_pkg::DIVISOR_W-1:0]   remainder
);
  localparam int VW = lps_pkg::DIVISOR_W;
  localparam int CW = $clog2(DW);

  logic [VW-1:0] acc;
  logic [DW-1:0] quo;
  logic [VW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic          ge;
  logic [VW:0]   diff;

  assign trial = {acc, quo[DW-1]};
  assign ge    = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        acc  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= '0;
      end else if (busy) begin
        acc <= ge ? diff[VW-1:0] : trial[VW-1:0];
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = acc;
endmodule

FILE: hw/rtl/lps_core.sv
module lps_core #(
  parameter int COUNT_BITS = lps_pkg::COUNT_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lps_pkg::cfg_t cfg_regs,
  lps_in_if.sink        tick,
  lps_out_if.source     result
);
  localparam int CB = COUNT_BITS;
  localparam int DW = COUNT_BITS + 16;
  localparam int VW = lps_pkg::DIVISOR_W;
  localparam int LW = lps_pkg::LEVEL_W;

  localparam logic [15:0] RECIP_5 = 16'd52429;
  localparam logic [15:0] RECIP_6 = 16'd43691;

  typedef enum logic [17:0] {
    ST_IDLE     = 18'h00001,
    ST_DISPATCH = 18'h00002,
    ST_MUL      = 18'h00004,
    ST_SHRINK   = 18'h00008,
    ST_CH_R     = 18'h00010,
    ST_CH_P     = 18'h00020,
    ST_PU_R     = 18'h00040,
    ST_PU_Q     = 18'h00080,
    ST_EO_R     = 18'h00100,
    ST_SH_R     = 18'h00200,
    ST_C2_CYC   = 18'h00400,
    ST_C2_CUR   = 18'h00800,
    ST_C2_M     = 18'h01000,
    ST_C2_PCT   = 18'h02000,
    ST_POP_Q    = 18'h04000,
    ST_FD_R     = 18'h08000,
    ST_RS_R     = 18'h10000,
    ST_OUT      = 18'h20000
  } state_t;

  state_t        state;
  logic [CB-1:0] elapsed;
  logic [CB-1:0] pop_start;
  logic [2:0]    mode;
  logic [2:0]    pending;
  logic [17:0]   idle_delay;
  logic [2:0]    pop_light;
  logic [LW-1:0] levels [lps_pkg::NUM_LIGHTS];
  logic          done_flag;
  logic          fade_done;
  logic [lps_pkg::RND_W-1:0] rnd;
  logic [DW-1:0] prod;
  logic [15:0]   per_s;
  logic [15:0]   step;
  logic [15:0]   cyc;
  logic [2:0]    cur;
  logic [2:0]    rnd_mod5;
  logic [2:0]    rnd_mod6;

  logic          div_go;
  logic [DW-1:0] div_a;
  logic [VW-1:0] div_b;
  logic          div_done;
  logic [DW-1:0] div_q;
  logic [VW-1:0] div_r;

  logic [VW-1:0] per_chase, per_pulse, per_eo, half_eo, per_fade, per_long, per_idle;
  logic [15:0]   base;
  logic [CB-1:0] pt;
  logic [DW-1:0] cut;
  logic [CB-1:0] long_ext;

  function automatic logic [VW-1:0] at_least_one(input logic [VW-1:0] v);
    return (v == '0) ? VW'(1) : v;
  endfunction

  // x / 5 and x / 6 by reciprocal multiply, exact for any 16-bit x
  function automatic logic [15:0] div_const(input logic [15:0] x, input logic [15:0] recip);
    logic [31:0] p;
    p = 32'(x) * 32'(recip);
    return 16'(p[31:18]);
  endfunction

  function automatic logic [LW-1:0] chase_level(input logic [6:0] pct, input logic [2:0] i);
    logic [8:0] s;
    s = 9'd200 + 9'(pct) - 9'(i) * 9'd17;
    if (s >= 9'd200) s = s - 9'd200;
    else if (s >= 9'd100) s = s - 9'd100;
    return lps_pkg::tri_level({s[7:0], 1'b0});
  endfunction

  assign per_chase = at_least_one(VW'(cfg_regs.chase_cycle_ms));
  assign per_pulse = at_least_one(VW'(cfg_regs.pulse_cycle_ms));
  assign per_eo    = at_least_one(VW'(cfg_regs.even_odd_cycle_ms));
  assign half_eo   = at_least_one({1'b0, per_eo[VW-1:1]});
  assign per_fade  = at_least_one(VW'(cfg_regs.fade_time_ms));
  assign per_long  = at_least_one(cfg_regs.long_timeout_ms);
  assign per_idle  = at_least_one(VW'(cfg_regs.idle_max_seconds));
  assign base      = (mode == lps_pkg::MODE_CHASE2) ? cfg_regs.chase2_cycle_ms
                                                    : cfg_regs.pop_pulse_ms;
  assign pt        = elapsed - pop_start;
  assign cut       = div_q;
  assign long_ext  = CB'(cfg_regs.long_timeout_ms);
  assign rnd_mod5  = 3'(16'(rnd) - div_const(16'(rnd), RECIP_5) * 16'd5);
  assign rnd_mod6  = 3'(16'(rnd) - div_const(16'(rnd), RECIP_6) * 16'd6);

  lps_div #(.DW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign tick.ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      elapsed      <= '0;
      pop_start    <= '0;
      mode         <= lps_pkg::MODE_RESET;
      pending      <= '0;
      idle_delay   <= '0;
      pop_light    <= lps_pkg::NO_LIGHT;
      done_flag    <= 1'b0;
      fade_done    <= 1'b0;
      div_go       <= 1'b0;
      result.valid <= 1'b0;
      for (int i = 0; i < lps_pkg::NUM_LIGHTS; i++) levels[i] <= '0;
    end else begin
      logic go_n;
      go_n = 1'b0;
      // in ST_OUT a taken result is always replaced by the new one
      if (result.valid && result.ready && state != ST_OUT) result.valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (tick.valid) begin
            elapsed <= elapsed + CB'(tick.step_ms);
            rnd     <= tick.random_word;
            state   <= ST_DISPATCH;
          end
        end

        ST_DISPATCH: begin
          unique case (mode)
            lps_pkg::MODE_CHASE: begin
              done_flag <= elapsed > long_ext;
              go_n = 1'b1; div_a <= DW'(elapsed); div_b <= per_chase;
              state <= ST_CH_R;
            end
            lps_pkg::MODE_PULSE: begin
              done_flag <= elapsed > CB'(4000);
              go_n = 1'b1; div_a <= DW'(elapsed); div_b <= per_pulse;
              state <= ST_PU_R;
            end
            lps_pkg::MODE_EVENODD: begin
              done_flag <= elapsed > long_ext;
              go_n = 1'b1; div_a <= DW'(elapsed); div_b <= per_eo;
              state <= ST_EO_R;
            end
            lps_pkg::MODE_CHASE2: begin
              done_flag <= elapsed > long_ext;
              state <= ST_MUL;
            end
            lps_pkg::MODE_POP: begin
              done_flag <= elapsed > long_ext;
              if (pop_light == lps_pkg::NO_LIGHT) begin
                pop_start <= elapsed;
                pop_light <= rnd_mod6;
                for (int i = 0; i < lps_pkg::NUM_LIGHTS; i++) levels[i] <= '0;
              end
              state <= ST_MUL;
            end
            lps_pkg::MODE_IDLE: begin
              if (elapsed > CB'(idle_delay)) begin
                elapsed <= '0;
                pending <= rnd_mod5;
                mode    <= lps_pkg::MODE_FADE;
              end
              state <= ST_OUT;
            end
            lps_pkg::MODE_FADE: begin
              fade_done <= elapsed > CB'(cfg_regs.fade_time_ms);
              go_n = 1'b1; div_a <= DW'(elapsed) * DW'(100); div_b <= per_fade;
              state <= ST_FD_R;
            end
            lps_pkg::MODE_RESET: begin
              for (int i = 0; i < lps_pkg::NUM_LIGHTS; i++) levels[i] <= LW'(100);
              elapsed <= '0;
              go_n = 1'b1; div_a <= DW'(rnd); div_b <= per_idle;
              state <= ST_RS_R;
            end
          endcase
        end

        ST_MUL: begin
          prod  <= DW'(base) * DW'(elapsed);
          state <= ST_SHRINK;
        end

        ST_SHRINK: begin
          go_n = 1'b1; div_a <= prod; div_b <= per_long;
          state <= ST_SH_R;
        end

        ST_SH_R: begin
          if (div_done) begin
            logic [15:0] ps;
            ps = (cut >= DW'(base)) ? 16'd0 : (base - cut[15:0]);
            per_s <= ps;
            if (mode == lps_pkg::MODE_CHASE2) begin
              for (int i = 0; i < lps_pkg::NUM_LIGHTS; i++) levels[i] <= '0;
              go_n = 1'b1; div_a <= DW'(elapsed); div_b <= VW'(ps);
              state <= ST_C2_CYC;
            end else if (ps == 16'd0 || pt > CB'(ps)) begin
              pop_light <= lps_pkg::NO_LIGHT;
              state     <= ST_OUT;
            end else if (pop_light < 3'd6) begin
              go_n = 1'b1; div_a <= DW'(pt[15:0]) * DW'(200); div_b <= VW'(ps);
              state <= ST_POP_Q;
            end else begin
              state <= ST_OUT;
            end
          end
        end

        ST_POP_Q: begin
          if (div_done) begin
            levels[pop_light] <= lps_pkg::tri_level(div_q[8:0]);
            state <= ST_OUT;
          end
        end

        // step = period / 6 settles long before the division ends;
        // a zero step leaves all lights dark
        ST_C2_CYC: begin
          step <= div_const(per_s, RECIP_6);
          if (div_done) begin
            if (step == 16'd0) begin
              state <= ST_OUT;
            end else begin
              cyc <= div_r[15:0];
              go_n = 1'b1; div_a <= DW'(div_r[15:0]) * DW'(6); div_b <= VW'(per_s);
              state <= ST_C2_CUR;
            end
          end
        end

        ST_C2_CUR: begin
          if (div_done) begin
            cur <= div_q[2:0];
            go_n = 1'b1; div_a <= DW'(cyc); div_b <= VW'(step);
            state <= ST_C2_M;
          end
        end

        ST_C2_M: begin
          if (div_done) begin
            go_n = 1'b1; div_a <= DW'(div_r[15:0]) * DW'(100); div_b <= VW'(step);
            state <= ST_C2_PCT;
          end
        end

        ST_C2_PCT: begin
          if (div_done) begin
            levels[cur] <= lps_pkg::tri_level({div_q[7:0], 1'b0});
            state <= ST_OUT;
          end
        end

        ST_CH_R: begin
          if (div_done) begin
            go_n = 1'b1; div_a <= DW'(div_r[15:0]) * DW'(100); div_b <= per_chase;
            state <= ST_CH_P;
          end
        end

        ST_CH_P: begin
          if (div_done) begin
            for (int i = 0; i < lps_pkg::NUM_LIGHTS; i++)
              levels[i] <= chase_level(div_q[6:0], 3'(i));
            state <= ST_OUT;
          end
        end

        ST_PU_R: begin
          if (div_done) begin
            go_n = 1'b1; div_a <= DW'(div_r[15:0]) * DW'(200); div_b <= per_pulse;
            state <= ST_PU_Q;
          end
        end

        ST_PU_Q: begin
          if (div_done) begin
            for (int i = 0; i < lps_pkg::NUM_LIGHTS; i++)
              levels[i] <= lps_pkg::tri_level(div_q[8:0]);
            state <= ST_OUT;
          end
        end

        ST_EO_R: begin
          if (div_done) begin
            for (int i = 0; i < lps_pkg::NUM_LIGHTS; i++)
              levels[i] <= ((i % 2 == 1) == (div_r >= half_eo)) ? LW'(100) : LW'(0);
            state <= ST_OUT;
          end
        end

        ST_FD_R: begin
          if (div_done) begin
            for (int i = 0; i < lps_pkg::NUM_LIGHTS; i++)
              levels[i] <= (div_q >= DW'(100)) ? LW'(0) : (LW'(100) - div_q[LW-1:0]);
            if (fade_done) begin
              elapsed <= '0;
              mode    <= pending;
            end
            state <= ST_OUT;
          end
        end

        ST_RS_R: begin
          if (div_done) begin
            idle_delay <= (18'(div_r[7:0]) + 18'd1) * 18'd1000;
            mode       <= lps_pkg::MODE_IDLE;
            state      <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!result.valid || result.ready) begin
            if (done_flag) begin
              elapsed   <= '0;
              mode      <= lps_pkg::MODE_RESET;
              pop_light <= lps_pkg::NO_LIGHT;
            end
            result.valid        <= 1'b1;
            result.level_0      <= levels[0];
            result.level_1      <= levels[1];
            result.level_2      <= levels[2];
            result.level_3      <= levels[3];
            result.level_4      <= levels[4];
            result.level_5      <= levels[5];
            result.pattern_mode <= done_flag ? lps_pkg::MODE_RESET : mode;
            done_flag           <= 1'b0;
            state               <= ST_IDLE;
          end
        end
      endcase

      div_go <= go_n;
    end
  end
endmodule

FILE: hw/rtl/led_pattern_sequencer.sv
// Channel | Dir | Payload                                   | Handshake
// tick    | in  | step_ms[15:0], random_word[14:0]          | valid/ready
// result  | out | level_0..level_5[6:0], pattern_mode[2:0]  | valid/ready
// cfg     | in  | index[2:0], data[19:0]                    | valid/ready (always ready)
//
// Every division goes through the shared one-bit-per-cycle divider. Idle mode uses no
// division; reset, fadeout and even/odd use one, chase and pulse two, pop two (one
// when a pulse ends) and the accelerating chase five. tick.ready is low while a tick
// is being worked on. A finished result sits in an output register, so the next tick
// is taken while it waits; a result still held when the next one is done stalls the
// core in its output state until the result is taken.
// Synchronous active-high rst restores the register defaults and reset mode.
module led_pattern_sequencer #(
  parameter int COUNT_BITS = lps_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  lps_in_if.sink    tick,
  lps_out_if.source result,
  lps_cfg_if.sink   cfg
);
  lps_pkg::cfg_t cfg_regs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= lps_pkg::CFG_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lps_pkg::REG_FADE_TIME:    cfg_regs.fade_time_ms      <= cfg.data[15:0];
        lps_pkg::REG_IDLE_MAX:     cfg_regs.idle_max_seconds  <= cfg.data[7:0];
        lps_pkg::REG_CHASE_CYCLE:  cfg_regs.chase_cycle_ms    <= cfg.data[15:0];
        lps_pkg::REG_PULSE_CYCLE:  cfg_regs.pulse_cycle_ms    <= cfg.data[15:0];
        lps_pkg::REG_EVENODD:      cfg_regs.even_odd_cycle_ms <= cfg.data[15:0];
        lps_pkg::REG_CHASE2_CYCLE: cfg_regs.chase2_cycle_ms   <= cfg.data[15:0];
        lps_pkg::REG_POP_PULSE:    cfg_regs.pop_pulse_ms      <= cfg.data[15:0];
        lps_pkg::REG_LONG_TIMEOUT: cfg_regs.long_timeout_ms   <= cfg.data[19:0];
      endcase
    end
  end

  lps_core #(.COUNT_BITS(COUNT_BITS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_regs (cfg_regs),
    .tick     (tick),
    .result   (result)
  );
endmodule
